// ===== sv/prim_minimum_spanning_tree_top_assert.svh =====
// Assertion macros used by the spanning tree datapath.
`ifndef PRIM_MINIMUM_SPANNING_TREE_TOP_ASSERT_SVH
`define PRIM_MINIMUM_SPANNING_TREE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PMST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PMST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pmst_pkg.sv =====
// Shared types, constants and microcode table of the spanning tree engine.
package pmst_pkg;

    localparam int MAX_NODES_DEF   = 64;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int CMD_W           = 2;
    localparam int NODE_W          = 6;
    localparam int EDGE_W          = 16;
    localparam int CFG_W           = 7;
    localparam int TOTAL_W         = 22;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_EDGE_AB,
        OP_EDGE_BA,
        OP_INIT,
        OP_SCAN_PREP,
        OP_SCAN,
        OP_TAKE,
        OP_RELAX,
        OP_NEXT,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_DISPATCH,
        SEQ_BR_NOT_FOUND,
        SEQ_BR_MORE
    } seq_t;

    typedef logic [3:0] upc_t;

    localparam upc_t UPC_CLEAR     = 4'd0;
    localparam upc_t UPC_IDLE      = 4'd1;
    localparam upc_t UPC_EDGE_AB   = 4'd2;
    localparam upc_t UPC_EDGE_BA   = 4'd3;
    localparam upc_t UPC_INIT      = 4'd4;
    localparam upc_t UPC_SCAN_PREP = 4'd5;
    localparam upc_t UPC_SCAN      = 4'd6;
    localparam upc_t UPC_TAKE      = 4'd7;
    localparam upc_t UPC_RELAX     = 4'd8;
    localparam upc_t UPC_NEXT      = 4'd9;
    localparam upc_t UPC_OUT       = 4'd10;

    typedef struct packed {
        op_t  op;
        seq_t seq;
        upc_t target;
    } ucode_t;

    typedef struct packed {
        logic             hold;
        logic             accepted;
        logic [CMD_W-1:0] cmd;
        logic             not_found;
        logic             more;
    } dp_status_t;

    // Control store: one word per step of the program.
    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        case (addr)
            UPC_CLEAR:     w = '{OP_CLEAR,     SEQ_JUMP,         UPC_IDLE};
            UPC_IDLE:      w = '{OP_IDLE,      SEQ_DISPATCH,     UPC_IDLE};
            UPC_EDGE_AB:   w = '{OP_EDGE_AB,   SEQ_NEXT,         UPC_IDLE};
            UPC_EDGE_BA:   w = '{OP_EDGE_BA,   SEQ_JUMP,         UPC_IDLE};
            UPC_INIT:      w = '{OP_INIT,      SEQ_NEXT,         UPC_IDLE};
            UPC_SCAN_PREP: w = '{OP_SCAN_PREP, SEQ_NEXT,         UPC_IDLE};
            UPC_SCAN:      w = '{OP_SCAN,      SEQ_NEXT,         UPC_IDLE};
            UPC_TAKE:      w = '{OP_TAKE,      SEQ_BR_NOT_FOUND, UPC_OUT};
            UPC_RELAX:     w = '{OP_RELAX,     SEQ_NEXT,         UPC_IDLE};
            UPC_NEXT:      w = '{OP_NEXT,      SEQ_BR_MORE,      UPC_SCAN_PREP};
            UPC_OUT:       w = '{OP_OUT,       SEQ_JUMP,         UPC_IDLE};
            default:       w = '{OP_IDLE,      SEQ_JUMP,         UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/pmst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/pmst_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
module pmst_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pmst_pkg::dp_status_t status,
    output pmst_pkg::ucode_t     ctrl
);
    import pmst_pkg::*;

    upc_t   pc_reg;
    upc_t   pc_next;
    upc_t   dispatch_pc;
    ucode_t word;

    assign word = ucode_rom(pc_reg);
    assign ctrl = word;

    always_comb
    begin
        case (status.cmd)
            CMD_CLEAR:   dispatch_pc = UPC_CLEAR;
            CMD_ADD:     dispatch_pc = UPC_EDGE_AB;
            CMD_COMPUTE: dispatch_pc = UPC_INIT;
            default:     dispatch_pc = UPC_IDLE;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (!status.hold)
        begin
            case (word.seq)
                SEQ_NEXT:         pc_next = pc_reg + 4'd1;
                SEQ_JUMP:         pc_next = word.target;
                SEQ_DISPATCH:     pc_next = status.accepted ? dispatch_pc : pc_reg;
                SEQ_BR_NOT_FOUND: pc_next = status.not_found ? word.target : pc_reg + 4'd1;
                SEQ_BR_MORE:      pc_next = status.more ? word.target : pc_reg + 4'd1;
                default:          pc_next = UPC_IDLE;
            endcase
        end
    end

    // Reset starts the program at the matrix clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= UPC_CLEAR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== sv/pmst_dp.sv =====
// Datapath: handshakes, loop counter, key scan, relaxation and result register.
module pmst_dp #(
    parameter int MAX_NODES   = pmst_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pmst_pkg::ucode_t                     ctrl,
    output pmst_pkg::dp_status_t                 status,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pmst_pkg::CMD_W-1:0]           command,
    input  logic [pmst_pkg::NODE_W-1:0]          node_a,
    input  logic [pmst_pkg::NODE_W-1:0]          node_b,
    input  logic [pmst_pkg::EDGE_W-1:0]          edge_weight,
    input  logic                                 cfg_wr_en,
    input  logic [pmst_pkg::CFG_W-1:0]           cfg_wr_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pmst_pkg::TOTAL_W-1:0]         tree_weight,
    output logic                                 connected,
    output logic                                 mat_we,
    output logic [2*$clog2(MAX_NODES)-1:0]       mat_waddr,
    output logic [WEIGHT_BITS-1:0]               mat_wdata,
    output logic [2*$clog2(MAX_NODES)-1:0]       mat_raddr,
    input  logic [WEIGHT_BITS-1:0]               mat_rdata,
    output logic                                 key_we,
    output logic [$clog2(MAX_NODES)-1:0]         key_waddr,
    output logic [WEIGHT_BITS+1:0]               key_wdata,
    output logic [$clog2(MAX_NODES)-1:0]         key_raddr,
    input  logic [WEIGHT_BITS+1:0]               key_rdata
);
    import pmst_pkg::*;

    `include "prim_minimum_spanning_tree_top_assert.svh"

    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MAT_DEPTH = 1 << ADDR_W;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int NCNT_W    = $clog2(MAX_NODES + 1);
    localparam int KEY_W     = WEIGHT_BITS + 1;
    localparam int SUM_W     = (KEY_W > TOTAL_W) ? KEY_W : TOTAL_W;
    localparam logic [KEY_W-1:0] KEY_INF = '1;

    logic [NCNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   d_valid_reg;
    logic [IDX_W-1:0]       d_idx_reg;
    logic [NODE_W-1:0]      a_reg, b_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [IDX_W-1:0]       pick_reg, pick_next;
    logic [KEY_W-1:0]       best_reg, best_next;
    logic                   found_reg, found_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   reached_reg, reached_next;
    logic [NCNT_W-1:0]      steps_reg, steps_next;
    logic                   out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0]     tree_weight_reg;
    logic                   connected_reg;

    op_t                    op;
    logic                   accepted;
    logic                   loop_op;
    logic                   read_op;
    logic [CNT_W-1:0]       limit;
    logic                   issue;
    logic                   hold;
    logic                   out_free;
    logic [IDX_W-1:0]       cnt_idx;
    logic                   in_range;
    logic                   rd_mark;
    logic [KEY_W-1:0]       rd_key;
    logic                   relax_upd;
    logic                   scan_upd;
    logic [SUM_W-1:0]       total_sum;

    assign op       = ctrl.op;
    assign in_stall = (op != OP_IDLE);
    assign accepted = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign loop_op = (op == OP_CLEAR) || (op == OP_INIT) || (op == OP_SCAN) || (op == OP_RELAX);
    assign read_op = (op == OP_SCAN) || (op == OP_RELAX);
    assign limit   = (op == OP_CLEAR) ? CNT_W'(MAT_DEPTH) : CNT_W'(n_reg);
    assign issue   = loop_op && (cnt_reg != limit);
    assign hold    = (loop_op && (issue || d_valid_reg)) || ((op == OP_OUT) && !out_free);
    assign cnt_idx = cnt_reg[IDX_W-1:0];

    assign in_range = (int'(a_reg) < MAX_NODES) && (int'(b_reg) < MAX_NODES);

    assign rd_mark   = key_rdata[KEY_W];
    assign rd_key    = key_rdata[KEY_W-1:0];
    assign relax_upd = (op == OP_RELAX) && d_valid_reg && (mat_rdata != '0) && !rd_mark &&
                       (KEY_W'(mat_rdata) < rd_key);
    assign scan_upd  = (op == OP_SCAN) && d_valid_reg && !rd_mark && (rd_key < best_reg);
    assign total_sum = SUM_W'(total_reg) + SUM_W'(best_reg);

    assign status.hold      = hold;
    assign status.accepted  = accepted;
    assign status.cmd       = command;
    assign status.not_found = !found_reg;
    assign status.more      = (steps_reg != n_reg);

    // Matrix port: clear sweep, symmetric edge writes, row reads during relaxation.
    always_comb
    begin
        mat_we    = 1'b0;
        mat_waddr = cnt_reg[ADDR_W-1:0];
        mat_wdata = '0;
        case (op)
            OP_CLEAR:
            begin
                mat_we = issue;
            end
            OP_EDGE_AB:
            begin
                mat_we    = in_range;
                mat_waddr = {IDX_W'(a_reg), IDX_W'(b_reg)};
                mat_wdata = w_reg;
            end
            OP_EDGE_BA:
            begin
                mat_we    = in_range;
                mat_waddr = {IDX_W'(b_reg), IDX_W'(a_reg)};
                mat_wdata = w_reg;
            end
            default:
            begin
                mat_we = 1'b0;
            end
        endcase
    end

    assign mat_raddr = {pick_reg, cnt_idx};

    // Key port: {mark, key} per node.
    always_comb
    begin
        key_we    = 1'b0;
        key_waddr = cnt_idx;
        key_wdata = '0;
        case (op)
            OP_INIT:
            begin
                key_we    = issue;
                key_wdata = {1'b0, (cnt_idx == '0) ? {KEY_W{1'b0}} : KEY_INF};
            end
            OP_TAKE:
            begin
                key_we    = found_reg;
                key_waddr = pick_reg;
                key_wdata = {1'b1, best_reg};
            end
            OP_RELAX:
            begin
                key_we    = relax_upd;
                key_waddr = d_idx_reg;
                key_wdata = {1'b0, KEY_W'(mat_rdata)};
            end
            default:
            begin
                key_we = 1'b0;
            end
        endcase
    end

    assign key_raddr = cnt_idx;

    always_comb
    begin
        n_next = n_reg;
        if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
            begin
                n_next = NCNT_W'(1);
            end
            else if (int'(cfg_wr_data) > MAX_NODES)
            begin
                n_next = NCNT_W'(MAX_NODES);
            end
            else
            begin
                n_next = NCNT_W'(cfg_wr_data);
            end
        end
    end

    always_comb
    begin
        cnt_next = '0;
        if (hold)
        begin
            cnt_next = issue ? cnt_reg + 1'b1 : cnt_reg;
        end
    end

    always_comb
    begin
        pick_next    = pick_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        total_next   = total_reg;
        reached_next = reached_reg;
        steps_next   = steps_reg;
        case (op)
            OP_INIT:
            begin
                total_next   = '0;
                reached_next = 1'b1;
                steps_next   = '0;
            end
            OP_SCAN_PREP:
            begin
                best_next  = KEY_INF;
                found_next = 1'b0;
            end
            OP_SCAN:
            begin
                if (scan_upd)
                begin
                    best_next  = rd_key;
                    pick_next  = d_idx_reg;
                    found_next = 1'b1;
                end
            end
            OP_TAKE:
            begin
                if (found_reg)
                begin
                    total_next = total_sum[TOTAL_W-1:0];
                    steps_next = steps_reg + 1'b1;
                end
                else
                begin
                    reached_next = 1'b0;
                end
            end
            default:
            begin
                best_next = best_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if ((op == OP_OUT) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= NCNT_W'(1);
            cnt_reg       <= '0;
            d_valid_reg   <= 1'b0;
            found_reg     <= 1'b0;
            total_reg     <= '0;
            reached_reg   <= 1'b0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            d_valid_reg   <= issue && read_op;
            found_reg     <= found_next;
            total_reg     <= total_next;
            reached_reg   <= reached_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_idx_reg <= cnt_idx;
        pick_reg  <= pick_next;
        best_reg  <= best_next;
        if (accepted)
        begin
            a_reg <= node_a;
            b_reg <= node_b;
            w_reg <= WEIGHT_BITS'(edge_weight);
        end
        if ((op == OP_OUT) && out_free)
        begin
            tree_weight_reg <= total_reg;
            connected_reg   <= reached_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tree_weight = tree_weight_reg;
    assign connected   = connected_reg;

    `PMST_ASSERT_NOW(a_out_from_out_step, $rose(out_valid_reg), $past(op == OP_OUT),
        "result word raised outside the output step")
    `PMST_ASSERT_NOW(a_found_is_finite, found_reg, best_reg != KEY_INF,
        "picked node carries an infinite key")
    `PMST_ASSERT_NOW(a_steps_bounded, (op == OP_TAKE) || (op == OP_RELAX) || (op == OP_NEXT),
        steps_reg <= n_reg, "more tree steps than nodes in use")
    `PMST_ASSERT_NOW(a_cnt_bounded, loop_op, cnt_reg <= limit,
        "loop counter ran past its limit")
    `PMST_ASSERT_NEXT(a_drain_after_issue, issue && read_op, d_valid_reg,
        "read issued without a following data cycle")

endmodule

// ===== sv/prim_minimum_spanning_tree_top.sv =====
// Add-edge word: dispatch, then the a-to-b and b-to-a matrix writes; clear word: a pass over
// all 2^(2*clog2(MAX_NODES)) matrix entries. Compute word: for n nodes in use, the key scan
// and row relaxation each walk n entries, one RAM entry per cycle. One word is worked at a time;
// the next is taken as soon as the program is back at its idle step.
// Reset: asynchronous, active low; node count returns to 1 and a clearing pass
// zeroes the matrix before the first word is taken.
module prim_minimum_spanning_tree_top #(
    parameter int MAX_NODES   = pmst_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [pmst_pkg::CMD_W-1:0]   command,
    input  logic [pmst_pkg::NODE_W-1:0]  node_a,
    input  logic [pmst_pkg::NODE_W-1:0]  node_b,
    input  logic [pmst_pkg::EDGE_W-1:0]  edge_weight,
    input  logic                         cfg_wr_en,
    input  logic [pmst_pkg::CFG_W-1:0]   cfg_wr_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pmst_pkg::TOTAL_W-1:0] tree_weight,
    output logic                         connected
);
    import pmst_pkg::*;

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int KEY_W  = WEIGHT_BITS + 1;

    // Control word from the sequencer and status back from the datapath.
    ucode_t     ctrl;
    dp_status_t status;

    // Adjacency matrix port: row = node index, column = neighbour index.
    logic                   mat_we;
    logic [ADDR_W-1:0]      mat_waddr;
    logic [WEIGHT_BITS-1:0] mat_wdata;
    logic [ADDR_W-1:0]      mat_raddr;
    logic [WEIGHT_BITS-1:0] mat_rdata;

    // Per-node key store: in-tree mark above the key; all-ones key means unreached.
    logic                   key_we;
    logic [IDX_W-1:0]       key_waddr;
    logic [KEY_W:0]         key_wdata;
    logic [IDX_W-1:0]       key_raddr;
    logic [KEY_W:0]         key_rdata;

    // Program: clear pass, idle/dispatch, two symmetric edge writes, then the Prim
    // loop of key initialise, scan for the cheapest unmarked node, take it, relax
    // its row, and branch back while nodes remain; an infinite minimum ends early.
    pmst_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Datapath: hold the word fields, run the loop counter, track the best key and
    // the running total, and park the result in an output register so the idle
    // step may take a new word while the result still waits.
    pmst_dp #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .node_a      (node_a),
        .node_b      (node_b),
        .edge_weight (edge_weight),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tree_weight (tree_weight),
        .connected   (connected),
        .mat_we      (mat_we),
        .mat_waddr   (mat_waddr),
        .mat_wdata   (mat_wdata),
        .mat_raddr   (mat_raddr),
        .mat_rdata   (mat_rdata),
        .key_we      (key_we),
        .key_waddr   (key_waddr),
        .key_wdata   (key_wdata),
        .key_raddr   (key_raddr),
        .key_rdata   (key_rdata)
    );

    // Weight matrix; a zero entry means no edge.
    pmst_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (1 << ADDR_W)
    ) u_mat_ram (
        .clk     (clk),
        .wr_en   (mat_we),
        .wr_addr (mat_waddr),
        .wr_data (mat_wdata),
        .rd_addr (mat_raddr),
        .rd_data (mat_rdata)
    );

    // Keys and marks; the n entries in use are rewritten at the start of every compute.
    pmst_ram #(
        .WIDTH (KEY_W + 1),
        .DEPTH (1 << IDX_W)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (key_waddr),
        .wr_data (key_wdata),
        .rd_addr (key_raddr),
        .rd_data (key_rdata)
    );

endmodule
